// ===== src/ama_pkg.sv =====
package ama_pkg;

  // Sample and window geometry
  localparam int SAMPLE_W     = 12;
  localparam int WINDOW_DEPTH = 8;
  localparam int DEPTH_LOG    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W        = SAMPLE_W + DEPTH_LOG;

  // Exact floor division of the sum by the depth: multiply by a rounded-up
  // reciprocal, then drop RECIP_SHIFT bits (exact for any sum below 2**SUM_W)
  localparam int RECIP_SHIFT = SUM_W + DEPTH_LOG;
  localparam int RECIP_W     = SUM_W + 1;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam int PROD_W = SUM_W + RECIP_W;

  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(WINDOW_DEPTH);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  // Controls handed from the top level to every window cell
  typedef struct packed {
    logic advance;
    logic prefill;
  } cell_ctrl_t;

endpackage

// ===== src/ama_cell.sv =====
module ama_cell (
  input  logic                         clk,
  input  ama_pkg::cell_ctrl_t          ctrl,
  input  logic [ama_pkg::SAMPLE_W-1:0] fill,
  input  logic [ama_pkg::SAMPLE_W-1:0] shift_in,
  output logic [ama_pkg::SAMPLE_W-1:0] q
);
  import ama_pkg::*;

  // Load the new sample everywhere on prefill, else take the neighbor's value
  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      q <= ctrl.prefill ? fill : shift_in;
    end
  end

endmodule

// ===== src/ama_avg.sv =====
module ama_avg (
  input  logic                         clk,
  input  logic                         load,
  input  logic [ama_pkg::SUM_W-1:0]    sum,
  output logic [ama_pkg::SAMPLE_W-1:0] average
);
  import ama_pkg::*;

  logic [PROD_W-1:0] prod;

  // Divide by the window depth through the reciprocal product
  assign prod = PROD_W'(sum) * PROD_W'(RECIP);

  // Hold the mean for the output side
  always_ff @(posedge clk) begin
    if (load) begin
      average <= prod[RECIP_SHIFT +: SAMPLE_W];
    end
  end

endmodule

// ===== src/adc_prefilled_moving_average.sv =====
// Channel  | Handshake              | Payload
// ---------+------------------------+----------------------------------
// input    | in_valid / in_ready    | operation (1 b), sample (12 b)
// output   | out_valid / out_ready  | average (12 b)
//
// One item per cycle while no result is stalled; a sample's mean is registered
// in the cells and running sum, then at the output after the reciprocal multiply.
// A clear transfers like a sample but gives no result.
// Synchronous reset empties the window and drops any pending result.
// A stalled output holds the mean; one more result waits in the sum stage.
module adc_prefilled_moving_average (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         operation,
  input  logic [ama_pkg::SAMPLE_W-1:0] sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ama_pkg::SAMPLE_W-1:0] average
);
  import ama_pkg::*;

  logic                in_xfer;
  logic                is_sample;
  logic                is_clear;
  logic                filled;
  logic                filled_next;
  logic [SUM_W-1:0]    window_sum;
  logic [SUM_W-1:0]    window_sum_next;
  logic                pending;
  logic                pending_next;
  logic                out_valid_next;
  logic                out_load;
  cell_ctrl_t          cell_ctrl;
  logic [SAMPLE_W-1:0] tap [WINDOW_DEPTH];

  // Move the pending sum into the output register when it is free
  assign out_load  = pending && (!out_valid || out_ready);
  assign in_ready  = !pending || out_load;
  assign in_xfer   = in_valid && in_ready;
  assign is_sample = in_xfer && (op_t'(operation) == OP_SAMPLE);
  assign is_clear  = in_xfer && (op_t'(operation) == OP_CLEAR);

  assign cell_ctrl.advance = is_sample;
  assign cell_ctrl.prefill = !filled;

  // Window cells: newest in cell 0, each cell passes its value down the row
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      ama_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .fill     (sample),
        .shift_in (sample),
        .q        (tap[i])
      );
    end else begin : g_body
      ama_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .fill     (sample),
        .shift_in (tap[i-1]),
        .q        (tap[i])
      );
    end
  end

  // Running sum: 0 on clear, depth x sample on prefill, else add new, drop oldest
  always_comb begin
    window_sum_next = window_sum;
    filled_next     = filled;
    if (is_clear) begin
      window_sum_next = '0;
      filled_next     = 1'b0;
    end else if (is_sample) begin
      filled_next = 1'b1;
      if (!filled) begin
        window_sum_next = SUM_W'(SUM_W'(sample) * DEPTH_SUM);
      end else begin
        window_sum_next = window_sum - SUM_W'(tap[WINDOW_DEPTH-1]) + SUM_W'(sample);
      end
    end
  end

  // Advance the result flags
  always_comb begin
    pending_next = pending;
    if (out_load) begin
      pending_next = 1'b0;
    end
    if (is_sample) begin
      pending_next = 1'b1;
    end
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    if (out_load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
      filled     <= 1'b0;
      pending    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      window_sum <= window_sum_next;
      filled     <= filled_next;
      pending    <= pending_next;
      out_valid  <= out_valid_next;
    end
  end

  ama_avg u_avg (
    .clk     (clk),
    .load    (out_load),
    .sum     (window_sum),
    .average (average)
  );

  // A pending result always comes from a filled window
  a_pending_filled: assert property (@(posedge clk) disable iff (rst)
    pending |-> filled)
    else $error("pending result with empty window");

  // A clear empties the window and zeroes the sum
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    is_clear |=> (!filled && window_sum == '0))
    else $error("clear left window state behind");

  // Every accepted sample leaves a pending result
  a_sample_pending: assert property (@(posedge clk) disable iff (rst)
    is_sample |=> pending)
    else $error("sample result lost");

  // The sum never exceeds a full window of maximum samples
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    (PROD_W'(window_sum) <= PROD_W'(WINDOW_DEPTH) * PROD_W'((1 << SAMPLE_W) - 1)))
    else $error("running sum out of range");

endmodule
